@@ rtl/cartesian_to_spherical_assert.svh @@
// Assertion macros for the cartesian-to-spherical RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef CARTESIAN_TO_SPHERICAL_ASSERT_SVH
`define CARTESIAN_TO_SPHERICAL_ASSERT_SVH

// Condition holds at every edge out of reset.
`define C2S_ASSERT_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("cartesian_to_spherical: invariant violated");

// Same-cycle implication.
`define C2S_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cartesian_to_spherical: implication violated");

// Next-cycle implication.
`define C2S_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cartesian_to_spherical: next-cycle check violated");

`endif

@@ rtl/c2s_pkg.sv @@
// Shared constants and elaboration-time functions for the spherical converter.
// No dependencies.
package c2s_pkg;

    localparam int ISQ_STEPS  = 32;   // result bits of the 64-bit square root
    localparam int LEAD_W     = 6;    // holds 0..ISQ_STEPS
    localparam int OPW        = 34;   // CORDIC operand width (signed)
    localparam int VW         = 64;   // CORDIC vector/angle accumulator width
    localparam int GUARD_BITS = 28;
    localparam int ANG_W      = 30;   // Q2.28 angle magnitude

    localparam logic signed [63:0] Q60_ONE = 64'sd1 <<< 60;

    // unsigned 64-bit quotient by restoring long division
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        int b;
        quo = '0;
        rem = '0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(1/5) in Q60, floor-exact series
    function automatic logic signed [63:0] atan_inv5_q60();
        logic signed [63:0] p;
        logic signed [63:0] sum;
        logic signed [63:0] term;
        int k;
        p   = udiv64(Q60_ONE, 64'd5);
        sum = '0;
        for (k = 0; k < 40; k++)
        begin
            if (p != 0)
            begin
                term = udiv64(p, 64'(2 * k + 1));
                sum  = ((k & 1) == 1) ? sum - term : sum + term;
                p    = udiv64(p, 64'd25);
            end
        end
        return sum;
    endfunction

    // atan(1/239) in Q60, floor-exact series
    function automatic logic signed [63:0] atan_inv239_q60();
        logic signed [63:0] p;
        logic signed [63:0] sum;
        logic signed [63:0] term;
        int k;
        p   = udiv64(Q60_ONE, 64'd239);
        sum = '0;
        for (k = 0; k < 40; k++)
        begin
            if (p != 0)
            begin
                term = udiv64(p, 64'(2 * k + 1));
                sum  = ((k & 1) == 1) ? sum - term : sum + term;
                p    = udiv64(p, 64'd57121);
            end
        end
        return sum;
    endfunction

    localparam logic signed [63:0] ATAN_INV5   = atan_inv5_q60();
    localparam logic signed [63:0] ATAN_INV239 = atan_inv239_q60();
    localparam logic signed [63:0] PI_Q60      = 16 * ATAN_INV5 - 4 * ATAN_INV239;
    localparam logic signed [63:0] HALF_PI_Q60 = 8 * ATAN_INV5 - 2 * ATAN_INV239;
    localparam logic [ANG_W-1:0]   PI_Q28      =
        ANG_W'((PI_Q60 + (64'sd1 <<< 31)) >>> 32);

    // atan(2^-i) in Q60
    function automatic logic signed [63:0] atan_pow2_q60(input int i);
        logic signed [63:0] sum;
        logic signed [63:0] term;
        int k;
        sum = '0;
        if (i == 0)
        begin
            sum = 4 * ATAN_INV5 - ATAN_INV239;
        end
        else
        begin
            for (k = 0; k < 31; k++)
            begin
                if (i * (2 * k + 1) <= 60)
                begin
                    term = udiv64(Q60_ONE >>> (i * (2 * k + 1)), 64'(2 * k + 1));
                    sum  = ((k & 1) == 1) ? sum - term : sum + term;
                end
            end
        end
        return sum;
    endfunction

endpackage

@@ rtl/c2s_isqrt.sv @@
// Pipelined 64-bit integer square root, one result bit per stage.
// Uses c2s_pkg; carries a sideband word alongside each transaction.
module c2s_isqrt
    import c2s_pkg::*;
#(
    parameter int SB_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [63:0]       in_rad,
    input  logic [SB_W-1:0]   in_sb,
    output logic              out_valid,
    output logic [31:0]       out_root,
    output logic [63:0]       out_rem,
    output logic [LEAD_W-1:0] out_lead,
    output logic [SB_W-1:0]   out_sb
);

    logic              valid_reg [ISQ_STEPS];
    logic [63:0]       rem_reg   [ISQ_STEPS];
    logic [63:0]       res_reg   [ISQ_STEPS];
    logic [LEAD_W-1:0] lead_reg  [ISQ_STEPS];
    logic [SB_W-1:0]   sb_reg    [ISQ_STEPS];

    for (genvar j = 0; j < ISQ_STEPS; j++)
    begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);

        logic              valid_in;
        logic [63:0]       rem_in;
        logic [63:0]       res_in;
        logic [LEAD_W-1:0] lead_in;
        logic [SB_W-1:0]   sb_in;
        logic [63:0]       trial;
        logic [63:0]       rem_next;
        logic [63:0]       res_next;
        logic [LEAD_W-1:0] lead_next;

        if (j == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = in_rad;
            assign res_in   = '0;
            assign lead_in  = '0;
            assign sb_in    = in_sb;
        end
        else
        begin : g_rest
            assign valid_in = valid_reg[j-1];
            assign rem_in   = rem_reg[j-1];
            assign res_in   = res_reg[j-1];
            assign lead_in  = lead_reg[j-1];
            assign sb_in    = sb_reg[j-1];
        end

        always_comb
        begin
            trial = res_in + BIT;
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                res_next  = (res_in >> 1) + BIT;
                lead_next = lead_in;
            end
            else
            begin
                rem_next  = rem_in;
                res_next  = res_in >> 1;
                // count leading steps with no root bit yet
                lead_next = (res_in == '0) ? lead_in + LEAD_W'(1) : lead_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else if (en)
                valid_reg[j] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                res_reg[j]  <= res_next;
                lead_reg[j] <= lead_next;
                sb_reg[j]   <= sb_in;
            end
        end
    end

    assign out_valid = valid_reg[ISQ_STEPS-1];
    assign out_root  = res_reg[ISQ_STEPS-1][31:0];
    assign out_rem   = rem_reg[ISQ_STEPS-1];
    assign out_lead  = lead_reg[ISQ_STEPS-1];
    assign out_sb    = sb_reg[ISQ_STEPS-1];

endmodule

@@ rtl/c2s_cordic.sv @@
// Pipelined vectoring CORDIC: angle of (a, b), b >= 0, in 0..pi as Q2.28.
// Uses c2s_pkg for the Q60 arctangent table and pi; one iteration per stage.
module c2s_cordic
    import c2s_pkg::*;
#(
    parameter int STEPS = 32,
    parameter int SB_W  = 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [OPW-1:0] in_a,
    input  logic signed [OPW-1:0] in_b,
    input  logic [SB_W-1:0]       in_sb,
    output logic                  out_valid,
    output logic [ANG_W-1:0]      out_angle,
    output logic [SB_W-1:0]       out_sb
);

    // entry stage: quadrant fold and guard scaling
    logic                  pre_valid_reg;
    logic signed [VW-1:0]  pre_vx_reg, pre_vy_reg, pre_acc_reg;
    logic                  pre_bzero_reg, pre_aneg_reg;
    logic [SB_W-1:0]       pre_sb_reg;

    logic signed [OPW-1:0] rx, ry;
    logic signed [VW-1:0]  pre_vx_next, pre_vy_next, pre_acc_next;

    always_comb
    begin
        if (in_a[OPW-1])
        begin
            rx           = in_b;
            ry           = -in_a;
            pre_acc_next = HALF_PI_Q60;
        end
        else
        begin
            rx           = in_a;
            ry           = in_b;
            pre_acc_next = '0;
        end
        pre_vx_next = VW'(rx) <<< GUARD_BITS;
        pre_vy_next = VW'(ry) <<< GUARD_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_valid_reg <= 1'b0;
        else if (en)
            pre_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_vx_reg    <= pre_vx_next;
            pre_vy_reg    <= pre_vy_next;
            pre_acc_reg   <= pre_acc_next;
            pre_bzero_reg <= (in_b == '0);
            pre_aneg_reg  <= in_a[OPW-1];
            pre_sb_reg    <= in_sb;
        end
    end

    // iteration stages
    logic                 it_valid_reg [STEPS];
    logic signed [VW-1:0] it_vx_reg    [STEPS];
    logic signed [VW-1:0] it_vy_reg    [STEPS];
    logic signed [VW-1:0] it_acc_reg   [STEPS];
    logic                 it_bzero_reg [STEPS];
    logic                 it_aneg_reg  [STEPS];
    logic [SB_W-1:0]      it_sb_reg    [STEPS];

    for (genvar j = 0; j < STEPS; j++)
    begin : g_iter
        localparam logic signed [VW-1:0] ANG = atan_pow2_q60(j);

        logic                 valid_in, bzero_in, aneg_in;
        logic signed [VW-1:0] vx_in, vy_in, acc_in;
        logic [SB_W-1:0]      sb_in;
        logic signed [VW-1:0] dx, dy;
        logic signed [VW-1:0] vx_next, vy_next, acc_next;

        if (j == 0)
        begin : g_first
            assign valid_in = pre_valid_reg;
            assign vx_in    = pre_vx_reg;
            assign vy_in    = pre_vy_reg;
            assign acc_in   = pre_acc_reg;
            assign bzero_in = pre_bzero_reg;
            assign aneg_in  = pre_aneg_reg;
            assign sb_in    = pre_sb_reg;
        end
        else
        begin : g_rest
            assign valid_in = it_valid_reg[j-1];
            assign vx_in    = it_vx_reg[j-1];
            assign vy_in    = it_vy_reg[j-1];
            assign acc_in   = it_acc_reg[j-1];
            assign bzero_in = it_bzero_reg[j-1];
            assign aneg_in  = it_aneg_reg[j-1];
            assign sb_in    = it_sb_reg[j-1];
        end

        always_comb
        begin
            dx = vy_in >>> j;
            dy = vx_in >>> j;
            if (!vy_in[VW-1])
            begin
                vx_next  = vx_in + dx;
                vy_next  = vy_in - dy;
                acc_next = acc_in + ANG;
            end
            else
            begin
                vx_next  = vx_in - dx;
                vy_next  = vy_in + dy;
                acc_next = acc_in - ANG;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                it_valid_reg[j] <= 1'b0;
            else if (en)
                it_valid_reg[j] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                it_vx_reg[j]    <= vx_next;
                it_vy_reg[j]    <= vy_next;
                it_acc_reg[j]   <= acc_next;
                it_bzero_reg[j] <= bzero_in;
                it_aneg_reg[j]  <= aneg_in;
                it_sb_reg[j]    <= sb_in;
            end
        end
    end

    // clamp to [0, pi]; on the a axis the angle is exact
    logic                 cl_valid_reg;
    logic signed [VW-1:0] cl_acc_reg, cl_acc_next;
    logic [SB_W-1:0]      cl_sb_reg;
    logic signed [VW-1:0] last_acc;

    assign last_acc = it_acc_reg[STEPS-1];

    always_comb
    begin
        if (it_bzero_reg[STEPS-1])
            cl_acc_next = it_aneg_reg[STEPS-1] ? PI_Q60 : '0;
        else if (last_acc[VW-1])
            cl_acc_next = '0;
        else if (last_acc > PI_Q60)
            cl_acc_next = PI_Q60;
        else
            cl_acc_next = last_acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cl_valid_reg <= 1'b0;
        else if (en)
            cl_valid_reg <= it_valid_reg[STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cl_acc_reg <= cl_acc_next;
            cl_sb_reg  <= it_sb_reg[STEPS-1];
        end
    end

    // round half up from Q60 to Q28
    logic                 rd_valid_reg;
    logic [ANG_W-1:0]     rd_angle_reg;
    logic [SB_W-1:0]      rd_sb_reg;
    logic signed [VW-1:0] rd_sum;

    assign rd_sum = cl_acc_reg + (64'sd1 <<< 31);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else if (en)
            rd_valid_reg <= cl_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_angle_reg <= rd_sum[32+ANG_W-1:32];
            rd_sb_reg    <= cl_sb_reg;
        end
    end

    assign out_valid = rd_valid_reg;
    assign out_angle = rd_angle_reg;
    assign out_sb    = rd_sb_reg;

endmodule

@@ rtl/cartesian_to_spherical.sv @@
// Cartesian (Q16.16) to spherical (radius Q16.16, polar Q2.28, azimuth signed Q3.28) converter.
// Two 32-stage square roots in series, then the two angle pipelines of CORDIC_STEPS
// iteration stages each. Throughput: one transaction per cycle while the skid entry is
// empty; an output register plus one skid entry keeps input open while a result waits.
// Reset: rst_n asynchronous, active low; clears all valid bits, data is not reset.
// Depends on c2s_pkg, c2s_isqrt, c2s_cordic and cartesian_to_spherical_assert.svh.
`include "cartesian_to_spherical_assert.svh"

module cartesian_to_spherical
    import c2s_pkg::*;
#(
    parameter int CORDIC_STEPS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // coord_x[31:0], coord_y[63:32], coord_z[95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata    // radius[31:0], polar_angle[61:32], azimuth[92:62], 0
);

    // Whole pipeline advances unless the skid entry is occupied.
    logic en;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    //------------------------------------------------------------------
    // S1: capture, magnitudes
    //------------------------------------------------------------------
    logic signed [31:0] in_x, in_y, in_z;
    assign in_x = s_tdata[31:0];
    assign in_y = s_tdata[63:32];
    assign in_z = s_tdata[95:64];

    logic               s1_valid_reg;
    logic signed [31:0] s1_x_reg, s1_y_reg, s1_z_reg;
    logic [31:0]        s1_mx_reg, s1_my_reg, s1_mz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x_reg  <= in_x;
            s1_y_reg  <= in_y;
            s1_z_reg  <= in_z;
            s1_mx_reg <= in_x[31] ? 32'(-in_x) : 32'(in_x);
            s1_my_reg <= in_y[31] ? 32'(-in_y) : 32'(in_y);
            s1_mz_reg <= in_z[31] ? 32'(-in_z) : 32'(in_z);
        end
    end

    //------------------------------------------------------------------
    // S2: squares (Q32.32)
    //------------------------------------------------------------------
    logic               s2_valid_reg;
    logic signed [31:0] s2_x_reg, s2_y_reg, s2_z_reg;
    logic [63:0]        s2_sqx_reg, s2_sqy_reg, s2_sqz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_x_reg   <= s1_x_reg;
            s2_y_reg   <= s1_y_reg;
            s2_z_reg   <= s1_z_reg;
            s2_sqx_reg <= 64'(s1_mx_reg) * 64'(s1_mx_reg);
            s2_sqy_reg <= 64'(s1_my_reg) * 64'(s1_my_reg);
            s2_sqz_reg <= 64'(s1_mz_reg) * 64'(s1_mz_reg);
        end
    end

    //------------------------------------------------------------------
    // S3: x^2 + y^2 ;  S4: + z^2
    //------------------------------------------------------------------
    logic               s3_valid_reg;
    logic signed [31:0] s3_x_reg, s3_y_reg, s3_z_reg;
    logic [63:0]        s3_sxy_reg, s3_sqz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_x_reg   <= s2_x_reg;
            s3_y_reg   <= s2_y_reg;
            s3_z_reg   <= s2_z_reg;
            s3_sxy_reg <= s2_sqx_reg + s2_sqy_reg;
            s3_sqz_reg <= s2_sqz_reg;
        end
    end

    logic               s4_valid_reg;
    logic signed [31:0] s4_x_reg, s4_y_reg, s4_z_reg;
    logic [63:0]        s4_sxy_reg, s4_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (en)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_x_reg   <= s3_x_reg;
            s4_y_reg   <= s3_y_reg;
            s4_z_reg   <= s3_z_reg;
            s4_sxy_reg <= s3_sxy_reg;
            s4_s_reg   <= s3_sxy_reg + s3_sqz_reg;
        end
    end

    //------------------------------------------------------------------
    // Square root of r^2; leading zero pairs give the theta scale k
    //------------------------------------------------------------------
    localparam int SB1_W = 64 + 3 * 32;

    logic              q1_valid;
    logic [31:0]       q1_root;
    logic [63:0]       q1_rem;
    logic [LEAD_W-1:0] q1_lead;
    logic [SB1_W-1:0]  q1_sb;

    c2s_isqrt #(
        .SB_W (SB1_W)
    ) u_isqrt_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_valid_reg),
        .in_rad    (s4_s_reg),
        .in_sb     ({s4_sxy_reg, s4_x_reg, s4_y_reg, s4_z_reg}),
        .out_valid (q1_valid),
        .out_root  (q1_root),
        .out_rem   (q1_rem),
        .out_lead  (q1_lead),
        .out_sb    (q1_sb)
    );

    logic [63:0]        q1_sxy;
    logic signed [31:0] q1_x, q1_y, q1_z;
    assign {q1_sxy, q1_x, q1_y, q1_z} = q1_sb;

    //------------------------------------------------------------------
    // S5: round radius, scale z and rho^2 by 2^k and 4^k
    //------------------------------------------------------------------
    logic [4:0] k_shift;
    assign k_shift = (q1_lead >= LEAD_W'(31)) ? 5'd31 : q1_lead[4:0];

    logic                  s5_valid_reg;
    logic [31:0]           s5_root_reg;
    logic [63:0]           s5_sxy_reg;
    logic signed [OPW-1:0] s5_a_reg;
    logic signed [31:0]    s5_x_reg, s5_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (en)
            s5_valid_reg <= q1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // round to nearest: remainder past the root means the upper neighbor
            s5_root_reg <= q1_root + 32'(q1_rem > 64'(q1_root));
            s5_sxy_reg  <= q1_sxy << {k_shift, 1'b0};
            s5_a_reg    <= OPW'(q1_z) <<< k_shift;
            s5_x_reg    <= q1_x;
            s5_y_reg    <= q1_y;
        end
    end

    //------------------------------------------------------------------
    // rho * 2^k
    //------------------------------------------------------------------
    localparam int SB2_W = 32 + OPW + 2 * 32;

    logic                  q2_valid;
    logic [31:0]           q2_root;
    logic [SB2_W-1:0]      q2_sb;
    logic [31:0]           q2_radius;
    logic signed [OPW-1:0] q2_a;
    logic signed [31:0]    q2_x, q2_y;
    logic [31:0]           q2_my;

    c2s_isqrt #(
        .SB_W (SB2_W)
    ) u_isqrt_rho (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_valid_reg),
        .in_rad    (s5_sxy_reg),
        .in_sb     ({s5_root_reg, s5_a_reg, s5_x_reg, s5_y_reg}),
        .out_valid (q2_valid),
        .out_root  (q2_root),
        .out_rem   (),
        .out_lead  (),
        .out_sb    (q2_sb)
    );

    assign {q2_radius, q2_a, q2_x, q2_y} = q2_sb;
    assign q2_my = q2_y[31] ? 32'(-q2_y) : 32'(q2_y);

    //------------------------------------------------------------------
    // Angle pipelines in lockstep: theta = atan2(rho, z), phi = atan2(|y|, x)
    //------------------------------------------------------------------
    logic             theta_valid;
    logic [ANG_W-1:0] theta_angle;
    logic [31:0]      theta_radius;

    c2s_cordic #(
        .STEPS (CORDIC_STEPS),
        .SB_W  (32)
    ) u_cordic_theta (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q2_valid),
        .in_a      (q2_a),
        .in_b      (signed'(OPW'(q2_root))),
        .in_sb     (q2_radius),
        .out_valid (theta_valid),
        .out_angle (theta_angle),
        .out_sb    (theta_radius)
    );

    logic             phi_valid;
    logic [ANG_W-1:0] phi_angle;
    logic             phi_neg;

    c2s_cordic #(
        .STEPS (CORDIC_STEPS),
        .SB_W  (1)
    ) u_cordic_phi (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q2_valid),
        .in_a      (OPW'(q2_x)),
        .in_b      (signed'(OPW'(q2_my))),
        .in_sb     (q2_y[31]),
        .out_valid (phi_valid),
        .out_angle (phi_angle),
        .out_sb    (phi_neg)
    );

    logic [ANG_W:0] tail_azimuth;
    assign tail_azimuth = phi_neg ? -{1'b0, phi_angle} : {1'b0, phi_angle};

    //------------------------------------------------------------------
    // Output register plus one skid entry
    //------------------------------------------------------------------
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      radius_reg, radius_next;
    logic [ANG_W-1:0] polar_reg, polar_next;
    logic [ANG_W:0]   azimuth_reg, azimuth_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [31:0]      skid_radius_reg, skid_radius_next;
    logic [ANG_W-1:0] skid_polar_reg, skid_polar_next;
    logic [ANG_W:0]   skid_azimuth_reg, skid_azimuth_next;

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        radius_next       = radius_reg;
        polar_next        = polar_reg;
        azimuth_next      = azimuth_reg;
        skid_valid_next   = skid_valid_reg;
        skid_radius_next  = skid_radius_reg;
        skid_polar_next   = skid_polar_reg;
        skid_azimuth_next = skid_azimuth_reg;
        if (!skid_valid_reg)
        begin
            // pipeline tail is consumed this cycle
            if (!out_valid_reg || m_tready)
            begin
                out_valid_next = theta_valid;
                radius_next    = theta_radius;
                polar_next     = theta_angle;
                azimuth_next   = tail_azimuth;
            end
            else if (theta_valid)
            begin
                skid_valid_next   = 1'b1;
                skid_radius_next  = theta_radius;
                skid_polar_next   = theta_angle;
                skid_azimuth_next = tail_azimuth;
            end
        end
        else if (m_tready)
        begin
            out_valid_next  = 1'b1;
            radius_next     = skid_radius_reg;
            polar_next      = skid_polar_reg;
            azimuth_next    = skid_azimuth_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radius_reg       <= radius_next;
        polar_reg        <= polar_next;
        azimuth_reg      <= azimuth_next;
        skid_radius_reg  <= skid_radius_next;
        skid_polar_reg   <= skid_polar_next;
        skid_azimuth_reg <= skid_azimuth_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, azimuth_reg, polar_reg, radius_reg};

    //------------------------------------------------------------------
    // Checks
    //------------------------------------------------------------------
    `C2S_ASSERT_IMPLIES(a_skid_needs_out, skid_valid_reg, out_valid_reg)
    `C2S_ASSERT_NEXT(a_skid_drains, skid_valid_reg && m_tready, !skid_valid_reg)
    `C2S_ASSERT_HOLDS(a_cordic_lockstep, theta_valid == phi_valid)
    `C2S_ASSERT_IMPLIES(a_polar_range, out_valid_reg, polar_reg <= PI_Q28)

endmodule
